@@ hw/rtl/tlp_pkg.sv @@
// telemetry line parser package: types, codes and shared helper functions
// no dependencies; used by tlp_num_acc and telemetry_line_parser
package tlp_pkg;

    localparam int unsigned VALUE_BITS_DEF = 32;

    typedef enum logic [2:0] {
        KIND_NONE    = 3'd0,
        KIND_ENCODER = 3'd1,
        KIND_FATAL   = 3'd2,
        KIND_PING    = 3'd3,
        KIND_PWM     = 3'd4,
        KIND_SPEED   = 3'd5,
        KIND_WARNING = 3'd6
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NO_CHK    = 3'd1,
        ST_BAD_TAIL  = 3'd2,
        ST_MISMATCH  = 3'd3,
        ST_TOK_COUNT = 3'd4,
        ST_BAD_NUM   = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_SIGN   = 2'd1,
        PH_DIGITS = 2'd2,
        PH_STOP   = 2'd3
    } phase_t;

    typedef struct packed {
        phase_t phase;
        logic   neg;
        logic   err;
    } num_flags_t;

    function automatic logic is_ws(input logic [7:0] b);
        return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    function automatic logic is_delim(input logic [7:0] b);
        return (b == 8'h20) || (b == 8'h3A) || (b == 8'h0A);
    endfunction

endpackage

@@ hw/rtl/telemetry_line_parser.sv @@
// telemetry line parser top level: byte-wise message classifier and decoder
// depends on tlp_pkg and tlp_num_acc
//
// channel | dir | tdata                     | tuser          | tlast
// s_      | in  | data_byte[7:0]            | has_byte       | end_of_message
// m_      | out | kind,status,left,right    | -              | -
//
// one transfer per cycle on the input while s_tready is high; each byte updates the running state registers
// the end transfer is classified from the state as updated by its own byte
// the result register loads at the end transfer and is valid on the next cycle
// s_tready is low only while a result waits and m_tready is low
// aresetn is synchronous, active low; all message state clears after each result
module telemetry_line_parser #(
    parameter int unsigned VALUE_BITS = tlp_pkg::VALUE_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] has_byte
    input  logic        s_tlast,   // end_of_message
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata    // [2:0] kind, [5:3] status, [37:6] left, [69:38] right
);
    logic        acc_s;
    logic        take;       // byte taken this cycle
    logic        fin;        // result computed this cycle
    logic [7:0]  b;

    logic [7:0]  sum_reg, sum_next;
    logic [7:0]  sbm_reg, sbm_next;
    logic        mark_reg, mark_next;
    logic [31:0] recent_reg, recent_next;
    logic [5:0]  tags_reg, tags_next;
    logic [1:0]  lead_reg, lead_next;
    logic [3:0]  tok_reg, tok_next;
    logic        in_tok_reg, in_tok_next;
    logic [2:0]  ttok_reg, ttok_next;
    logic        tin_reg, tin_next;
    logic        has_reg, has_next;

    logic        out_v_reg;
    logic [71:0] out_d_reg;

    logic        marker_hit, delim, tail_clear;
    logic        left_feed, right_feed, tail_feed;
    logic        left_ok, right_ok, tail_ok;
    logic [VALUE_BITS-1:0] left_v, right_v, tail_v;

    tlp_pkg::kind_t   kind;
    tlp_pkg::status_t status;
    logic [31:0] lv, rv;

    assign s_tready = !out_v_reg || m_tready;
    assign acc_s    = s_tvalid && s_tready;
    assign b        = s_tdata;
    assign take     = acc_s && s_tuser;
    // end transfer, with or without a byte, finishes in the same cycle
    assign fin      = acc_s && s_tlast;

    assign delim      = tlp_pkg::is_delim(b);
    assign marker_hit = (b == 8'h3A) && (recent_reg == 32'h2063686B);

    // token counter next value for steering the number feeders
    always_comb begin
        tok_next    = tok_reg;
        in_tok_next = in_tok_reg;
        if (take) begin
            if (delim) begin
                in_tok_next = 1'b0;
            end else if (!in_tok_reg) begin
                in_tok_next = 1'b1;
                if (tok_reg != 4'd15) tok_next = tok_reg + 4'd1;
            end
        end
    end

    always_comb begin
        ttok_next = ttok_reg;
        tin_next  = tin_reg;
        if (take) begin
            if (marker_hit) begin
                ttok_next = '0;
                tin_next  = 1'b0;
            end else if (mark_reg) begin
                if (delim) begin
                    tin_next = 1'b0;
                end else if (!tin_reg) begin
                    tin_next = 1'b1;
                    if (ttok_reg != 3'd7) ttok_next = ttok_reg + 3'd1;
                end
            end
        end
    end

    assign left_feed  = take && !delim && tok_next == 4'd3;
    assign right_feed = take && !delim && tok_next == 4'd5;
    assign tail_feed  = take && !marker_hit && mark_reg && !delim && ttok_next == 3'd1;
    assign tail_clear = fin || (take && marker_hit);

    always_comb begin
        sum_next    = sum_reg;
        sbm_next    = sbm_reg;
        mark_next   = mark_reg;
        recent_next = recent_reg;
        tags_next   = tags_reg;
        lead_next   = lead_reg;
        has_next    = has_reg;
        if (take) begin
            has_next = 1'b1;
            if (lead_reg == 2'd0 && !tlp_pkg::is_ws(b)) lead_next = (b == 8'h21) ? 2'd1 : 2'd2;
            if (recent_reg[7:0] == 8'h21) begin
                case (b)
                    8'h65:   tags_next[0] = 1'b1;
                    8'h66:   tags_next[1] = 1'b1;
                    8'h70:   tags_next[2] = 1'b1;
                    8'h6D:   tags_next[3] = 1'b1;
                    8'h73:   tags_next[4] = 1'b1;
                    8'h77:   tags_next[5] = 1'b1;
                    default: tags_next = tags_reg;
                endcase
            end
            if (marker_hit) begin
                mark_next = 1'b1;
                sbm_next  = sum_reg - 8'h56;   // drop " chk" from the sum
            end
            sum_next    = sum_reg + b;
            recent_next = {recent_reg[23:0], b};
        end
    end

    tlp_num_acc #(.VALUE_BITS(VALUE_BITS)) u_left (
        .aclk, .aresetn, .clear(fin), .feed(left_feed), .data(b),
        .ok(left_ok), .value(left_v));
    tlp_num_acc #(.VALUE_BITS(VALUE_BITS)) u_right (
        .aclk, .aresetn, .clear(fin), .feed(right_feed), .data(b),
        .ok(right_ok), .value(right_v));
    tlp_num_acc #(.VALUE_BITS(VALUE_BITS)) u_tail (
        .aclk, .aresetn, .clear(tail_clear), .feed(tail_feed), .data(b),
        .ok(tail_ok), .value(tail_v));

    // classify from the state including the current byte
    always_comb begin
        kind   = tlp_pkg::KIND_NONE;
        status = tlp_pkg::ST_OK;
        if (has_next && lead_next == 2'd1) begin
            if (tags_next[0])      kind = tlp_pkg::KIND_ENCODER;
            else if (tags_next[1]) kind = tlp_pkg::KIND_FATAL;
            else if (tags_next[2]) kind = tlp_pkg::KIND_PING;
            else if (tags_next[3]) kind = tlp_pkg::KIND_PWM;
            else if (tags_next[4]) kind = tlp_pkg::KIND_SPEED;
            else if (tags_next[5]) kind = tlp_pkg::KIND_WARNING;
        end
        if (kind == tlp_pkg::KIND_ENCODER || kind == tlp_pkg::KIND_PWM
            || kind == tlp_pkg::KIND_SPEED) begin
            if (!mark_next)                         status = tlp_pkg::ST_NO_CHK;
            else if (ttok_next != 3'd1 || !tail_ok) status = tlp_pkg::ST_BAD_TAIL;
            else if (tail_v[7:0] != sbm_next)       status = tlp_pkg::ST_MISMATCH;
            else if (tok_next != 4'd7)              status = tlp_pkg::ST_TOK_COUNT;
            else if (!left_ok || !right_ok)         status = tlp_pkg::ST_BAD_NUM;
        end
        lv = '0;
        rv = '0;
        if ((kind == tlp_pkg::KIND_ENCODER || kind == tlp_pkg::KIND_PWM
             || kind == tlp_pkg::KIND_SPEED) && status == tlp_pkg::ST_OK) begin
            for (int i = 0; i < 32; i++) begin
                lv[i] = (i < VALUE_BITS) ? left_v[i % VALUE_BITS] : left_v[VALUE_BITS-1];
                rv[i] = (i < VALUE_BITS) ? right_v[i % VALUE_BITS] : right_v[VALUE_BITS-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || fin) begin
            sum_reg    <= '0;
            sbm_reg    <= '0;
            mark_reg   <= 1'b0;
            recent_reg <= '0;
            tags_reg   <= '0;
            lead_reg   <= 2'd0;
            tok_reg    <= '0;
            in_tok_reg <= 1'b0;
            ttok_reg   <= '0;
            tin_reg    <= 1'b0;
            has_reg    <= 1'b0;
        end else begin
            sum_reg    <= sum_next;
            sbm_reg    <= sbm_next;
            mark_reg   <= mark_next;
            recent_reg <= recent_next;
            tags_reg   <= tags_next;
            lead_reg   <= lead_next;
            tok_reg    <= tok_next;
            in_tok_reg <= in_tok_next;
            ttok_reg   <= ttok_next;
            tin_reg    <= tin_next;
            has_reg    <= has_next;
        end
    end

    // fin needs s_tready, so the output stage is free whenever it loads
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else begin
            if (fin)           out_v_reg <= 1'b1;
            else if (m_tready) out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fin) out_d_reg <= {2'b00, rv, lv, status, kind};
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_d_reg;

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        fin |-> !out_v_reg || m_tready) else $error("result overwritten");
    a_fin_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        fin |=> !has_reg && tags_reg == '0) else $error("state not cleared");
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("waiting result changed");
    a_result_after_end: assert property (@(posedge aclk) disable iff (!aresetn)
        acc_s && s_tlast |=> m_tvalid) else $error("missing result");

endmodule

@@ hw/rtl/tlp_num_acc.sv @@
// stoi-style signed decimal accumulator, one byte per transfer
// depends on tlp_pkg
module tlp_num_acc #(
    parameter int unsigned VALUE_BITS = tlp_pkg::VALUE_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  clear,
    input  logic                  feed,
    input  logic [7:0]            data,
    output logic                  ok,
    output logic [VALUE_BITS-1:0] value
);
    localparam logic [VALUE_BITS:0] LIMIT = {2'b01, {(VALUE_BITS-1){1'b0}}};

    logic [VALUE_BITS:0]   acc_reg, acc_next;
    tlp_pkg::num_flags_t   fl_reg, fl_next;
    logic                  dig;
    logic [3:0]            d;
    logic [VALUE_BITS+4:0] prod;

    assign dig  = (data >= 8'h30) && (data <= 8'h39);
    assign d    = data[3:0];
    assign prod = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                + {{(VALUE_BITS+1){1'b0}}, d};

    // next value with this byte fed in; clear acts on the register only
    always_comb begin
        acc_next = acc_reg;
        fl_next  = fl_reg;
        if (feed && fl_reg.phase != tlp_pkg::PH_STOP) begin
            if (fl_reg.phase == tlp_pkg::PH_IDLE && tlp_pkg::is_ws(data)) begin
                fl_next = fl_reg;
            end else if (fl_reg.phase == tlp_pkg::PH_IDLE
                         && (data == 8'h2B || data == 8'h2D)) begin
                fl_next.phase = tlp_pkg::PH_SIGN;
                fl_next.neg   = (data == 8'h2D);
            end else if (!dig) begin
                if (fl_reg.phase != tlp_pkg::PH_DIGITS) fl_next.err = 1'b1;
                fl_next.phase = tlp_pkg::PH_STOP;
            end else begin
                fl_next.phase = tlp_pkg::PH_DIGITS;
                if (!fl_reg.err) begin
                    // overflow when acc*10+d exceeds the limit
                    if (prod > {4'b0000, LIMIT}) begin
                        fl_next.err = 1'b1;
                    end else begin
                        acc_next = prod[VALUE_BITS:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            acc_reg <= '0;
            fl_reg  <= '{phase: tlp_pkg::PH_IDLE, neg: 1'b0, err: 1'b0};
        end else begin
            acc_reg <= acc_next;
            fl_reg  <= fl_next;
        end
    end

    // valid number including the byte fed this cycle
    assign ok = !fl_next.err && (fl_next.phase == tlp_pkg::PH_DIGITS
                                 || fl_next.phase == tlp_pkg::PH_STOP)
              && (fl_next.neg || acc_next < LIMIT);
    assign value = fl_next.neg ? VALUE_BITS'(-acc_next) : acc_next[VALUE_BITS-1:0];

    a_acc_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        acc_reg <= LIMIT) else $error("accumulator above limit");
    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clear |=> acc_reg == '0 && fl_reg.phase == tlp_pkg::PH_IDLE)
        else $error("clear not taken");
    a_stop_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        fl_reg.phase == tlp_pkg::PH_STOP && !clear |=> $stable(acc_reg))
        else $error("stopped number changed");

endmodule
